>>> rtl/core/ge3_pkg.sv
// shared constants, types and helpers for the 3x3 grayscale erosion core
package ge3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W_W     = 11;
  localparam int CFG_H_W     = 16;
  localparam int WCMP_W      = (ADDR_W + 1 > CFG_W_W) ? ADDR_W + 1 : CFG_W_W;
  localparam int PIX_W       = 8;
  localparam int COL_OUT_W   = 10;
  localparam int ROW_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0]     pix_top;
    logic [PIX_W-1:0]     pix_mid;
    logic [PIX_W-1:0]     pix_new;
    logic                 emit;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } item_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

>>> rtl/core/ge3_front.sv
// front end: frame counters, line stores and beat classification
module ge3_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ge3_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ge3_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                pixel_valid_i,
  input  logic [ge3_pkg::PIX_W-1:0]           pixel_value_i,
  output logic                                pixel_stall_o,
  input  logic [ge3_pkg::QCNT_W-1:0]          q_count_i,
  output logic                                push_o,
  output ge3_pkg::item_t                      item_o
);

  logic [ge3_pkg::CFG_W_W-1:0]   width_q;
  logic [ge3_pkg::CFG_H_W-1:0]   height_q;
  logic [ge3_pkg::ADDR_W-1:0]    col_q, col_d;
  logic [ge3_pkg::ROW_W-1:0]     row_q, row_d;
  logic [ge3_pkg::WCMP_W-1:0]    w_ext, w_eff, c_ext, c_inc, colm1;
  logic [ge3_pkg::ROW_W-1:0]     h_eff;
  logic [ge3_pkg::ROW_W:0]       r_inc;
  logic                          accept;
  logic                          emit, last;
  logic [ge3_pkg::QCNT_W-1:0]    level;

  logic                          s1_valid_q;
  logic [ge3_pkg::PIX_W-1:0]     s1_pix_q;
  logic [ge3_pkg::ADDR_W-1:0]    s1_idx_q;
  logic                          s1_emit_q, s1_last_q;
  logic [ge3_pkg::COL_OUT_W-1:0] s1_col_q;
  logic [ge3_pkg::ROW_W-1:0]     s1_row_q;
  logic [2*ge3_pkg::PIX_W-1:0]   rd_q;
  logic [2*ge3_pkg::PIX_W-1:0]   mem [ge3_pkg::MAX_WIDTH];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ge3_pkg::WIDTH_RESET;
      height_q <= ge3_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ge3_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i[ge3_pkg::CFG_W_W-1:0];
        ge3_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i[ge3_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  assign level = q_count_i + ge3_pkg::QCNT_W'(s1_valid_q);
  assign pixel_stall_o = (level >= ge3_pkg::QCNT_W'(ge3_pkg::QUEUE_DEPTH));
  assign accept = pixel_valid_i && !pixel_stall_o;

  // effective frame size and position decode
  always_comb begin
    w_ext = ge3_pkg::WCMP_W'(width_q);
    if (w_ext < ge3_pkg::WCMP_W'(3)) begin
      w_eff = ge3_pkg::WCMP_W'(3);
    end else if (w_ext > ge3_pkg::WCMP_W'(ge3_pkg::MAX_WIDTH)) begin
      w_eff = ge3_pkg::WCMP_W'(ge3_pkg::MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_q < ge3_pkg::CFG_H_W'(3)) ? ge3_pkg::CFG_H_W'(3) : height_q;
    c_ext = ge3_pkg::WCMP_W'(col_q);
    c_inc = c_ext + ge3_pkg::WCMP_W'(1);
    r_inc = {1'b0, row_q} + 17'd1;
    colm1 = c_ext - ge3_pkg::WCMP_W'(1);
    emit  = (c_ext >= ge3_pkg::WCMP_W'(2)) && (row_q >= 16'd2)
         && (c_ext < w_eff) && (row_q < h_eff);
    last  = (c_ext == w_eff - ge3_pkg::WCMP_W'(1)) && (row_q == h_eff - 16'd1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      row_d = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ge3_pkg::ROW_W-1:0];
    end else begin
      col_d = c_inc[ge3_pkg::ADDR_W-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_value_i;
      s1_idx_q  <= col_q;
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_col_q  <= colm1[ge3_pkg::COL_OUT_W-1:0];
      s1_row_q  <= row_q - 16'd1;
    end
  end

  // line stores: upper byte previous row, lower byte the row before
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[col_q];
    end
    if (s1_valid_q) begin
      mem[s1_idx_q] <= {s1_pix_q, rd_q[2*ge3_pkg::PIX_W-1:ge3_pkg::PIX_W]};
    end
  end

  assign push_o          = s1_valid_q;
  assign item_o.pix_top  = rd_q[ge3_pkg::PIX_W-1:0];
  assign item_o.pix_mid  = rd_q[2*ge3_pkg::PIX_W-1:ge3_pkg::PIX_W];
  assign item_o.pix_new  = s1_pix_q;
  assign item_o.emit     = s1_emit_q;
  assign item_o.col      = s1_col_q;
  assign item_o.row      = s1_row_q;
  assign item_o.last     = s1_last_q;

endmodule

>>> rtl/core/ge3_queue.sv
// short fifo between front end and window back end
module ge3_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  ge3_pkg::item_t             item_i,
  input  logic                       pop_i,
  output ge3_pkg::item_t             item_o,
  output logic                       valid_o,
  output logic [ge3_pkg::QCNT_W-1:0] count_o
);

  ge3_pkg::item_t                   slot_q [ge3_pkg::QUEUE_DEPTH];
  logic [ge3_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [ge3_pkg::QCNT_W-1:0]       count_q;
  logic                             do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign item_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + ge3_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + ge3_pkg::QPTR_W'(1);
      end
      count_q <= count_q + ge3_pkg::QCNT_W'(push_i) - ge3_pkg::QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/core/ge3_back.sv
// back end: 3x3 window, min tree and result register
module ge3_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            head_valid_i,
  input  ge3_pkg::item_t                  head_i,
  output logic                            pop_o,
  output logic                            result_valid_o,
  input  logic                            result_stall_i,
  output logic [ge3_pkg::PIX_W-1:0]       eroded_value_o,
  output logic [ge3_pkg::PIX_W-1:0]       centre_value_o,
  output logic [ge3_pkg::COL_OUT_W-1:0]   out_column_o,
  output logic [ge3_pkg::ROW_W-1:0]       out_row_o,
  output logic                            frame_last_o
);

  // [row][col], row 0 oldest line, col 2 newest
  logic [ge3_pkg::PIX_W-1:0]     win_q [3][3];
  logic [ge3_pkg::PIX_W-1:0]     m_a, m_b, m_c, m_d, m_e, m_f, m_g, m_min;
  logic                          load_ok, load;
  logic                          out_valid_q, out_valid_d;
  logic [ge3_pkg::PIX_W-1:0]     ero_q, ctr_q;
  logic [ge3_pkg::COL_OUT_W-1:0] col_q;
  logic [ge3_pkg::ROW_W-1:0]     row_q;
  logic                          last_q;

  assign load_ok = !out_valid_q || !result_stall_i;
  assign pop_o   = head_valid_i && (!head_i.emit || load_ok);
  assign load    = pop_o && head_i.emit;

  // min over the shifted window
  always_comb begin
    m_a   = ge3_pkg::min2(win_q[0][1], win_q[0][2]);
    m_b   = ge3_pkg::min2(win_q[1][1], win_q[1][2]);
    m_c   = ge3_pkg::min2(win_q[2][1], win_q[2][2]);
    m_d   = ge3_pkg::min2(head_i.pix_top, head_i.pix_mid);
    m_e   = ge3_pkg::min2(m_a, m_b);
    m_f   = ge3_pkg::min2(m_c, m_d);
    m_g   = ge3_pkg::min2(m_e, m_f);
    m_min = ge3_pkg::min2(m_g, head_i.pix_new);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!result_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= head_i.pix_top;
        win_q[1][2] <= head_i.pix_mid;
        win_q[2][2] <= head_i.pix_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ero_q  <= m_min;
      ctr_q  <= win_q[1][2];
      col_q  <= head_i.col;
      row_q  <= head_i.row;
      last_q <= head_i.last;
    end
  end

  assign result_valid_o = out_valid_q;
  assign eroded_value_o = ero_q;
  assign centre_value_o = ctr_q;
  assign out_column_o   = col_q;
  assign out_row_o      = row_q;
  assign frame_last_o   = last_q;

endmodule

>>> rtl/core/gray_erosion_3x3_stream_core.sv
// top level of the 3x3 grayscale erosion stream core
//
//   channel   handshake                      payload
//   cfg       cfg_we_i                       cfg_index_i, cfg_wdata_i
//   pixel     pixel_valid_i / pixel_stall_o  pixel_value_i
//   result    result_valid_o / result_stall_i eroded_value_o, centre_value_o,
//                                            out_column_o, out_row_o, frame_last_o
//
// one pixel beat per cycle sustained while pixel_stall_o stays low; a result is produced from its beat
// through the registered line store read, the fifo and the result register
// reset clears counters, window and handshake state; line stores are not cleared
// pixel_stall_o rises when the fifo and the line store stage together hold four beats
// a stalled result holds while beats without a result keep draining the fifo
module gray_erosion_3x3_stream_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ge3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ge3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            pixel_valid_i,
  output logic                            pixel_stall_o,
  input  logic [ge3_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            result_valid_o,
  input  logic                            result_stall_i,
  output logic [ge3_pkg::PIX_W-1:0]       eroded_value_o,
  output logic [ge3_pkg::PIX_W-1:0]       centre_value_o,
  output logic [ge3_pkg::COL_OUT_W-1:0]   out_column_o,
  output logic [ge3_pkg::ROW_W-1:0]       out_row_o,
  output logic                            frame_last_o
);

  logic                          push, pop, head_valid;
  ge3_pkg::item_t                push_item, head_item;
  logic [ge3_pkg::QCNT_W-1:0]    q_count;

  ge3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_value_i (pixel_value_i),
    .pixel_stall_o (pixel_stall_o),
    .q_count_i     (q_count),
    .push_o        (push),
    .item_o        (push_item)
  );

  ge3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .valid_o (head_valid),
    .count_o (q_count)
  );

  ge3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .eroded_value_o (eroded_value_o),
    .centre_value_o (centre_value_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .frame_last_o   (frame_last_o)
  );

endmodule
